/* rtl/core/aae_pkg.sv */
// Shared constants, types and command/status structs of the adaptive arithmetic encoder.
package aae_pkg;

  localparam int unsigned RANGE_TOP   = 65535;
  localparam int unsigned CODE_W      = 16;
  localparam int unsigned WORK_W      = CODE_W + 1;
  localparam int unsigned HALF        = (RANGE_TOP + 1) / 2;
  localparam int unsigned QTR         = (RANGE_TOP + 1) / 4;
  localparam int unsigned Q3          = (3 * (RANGE_TOP + 1)) / 4;
  localparam int unsigned PEND_W      = 7;
  localparam int unsigned PENDING_MAX = 127;
  localparam int unsigned CNT_W       = 14;
  localparam int unsigned TBL_DEPTH   = 258;
  localparam int unsigned TBL_AW      = 9;
  localparam int unsigned EOS_SYM     = 256;
  localparam int unsigned RES_MAX     = 40;
  localparam int unsigned RES_AW      = 6;
  localparam int unsigned PROD_W      = WORK_W + CNT_W;
  localparam int unsigned DIVC_W      = 5;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD_HI, S_RD_TOT, S_MUL_LO, S_DIV_LO, S_MUL_HI, S_DIV_HI,
    S_SET_HI, S_INC, S_HALVE_INIT, S_HALVE, S_RENORM, S_PEND, S_FIN, S_FPEND,
    S_FLUSH, S_DRD, S_SHOW
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLR, OP_LOAD, OP_RD_HI, OP_RD_TOT, OP_MUL_LO, OP_DIV, OP_MUL_HI,
    OP_SET_HI, OP_INC, OP_HALVE_INIT, OP_HALVE, OP_RENORM, OP_PEND, OP_FIN,
    OP_FLUSH
  } dp_op_t;

  typedef enum logic [1:0] {
    OPX_NONE, OPX_DRD, OPX_SHOW
  } drain_op_t;

  typedef struct packed {
    dp_op_t    op;
    drain_op_t dop;
    logic      out_taken;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic sweep_done;
    logic need_halve;
    logic rn_stop;
    logic rn_emit;
    logic pend_nz;
    logic pend_last;
    logic fifo_empty;
    logic drain_last;
    logic eos;
  } dp_sts_t;

endpackage

/* rtl/core/aae_in_if.sv */
// Input channel: one byte or an end-of-stream mark per transfer.
interface aae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sym_byte;
  logic       end_of_stream;

  modport source (output valid, output sym_byte, output end_of_stream, input ready);
  modport sink (input valid, input sym_byte, input end_of_stream, output ready);
endinterface

/* rtl/core/aae_out_if.sv */
// Result channel: one coded byte with its flags per transfer.
interface aae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_done;
  logic       pending_overflow;

  modport source (output valid, output out_byte, output last_of_run, output stream_done,
                  output pending_overflow, input ready);
  modport sink (input valid, input out_byte, input last_of_run, input stream_done,
                input pending_overflow, output ready);
endinterface

/* rtl/core/aae_ctrl.sv */
// Sequencer of the encoder: walks each item through read, divide, adapt, renorm and drain.
module aae_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  aae_pkg::dp_sts_t sts,
  output aae_pkg::dp_cmd_t cmd
);

  aae_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aae_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aae_pkg::S_CLEAR:      if (sts.clr_last) state_nxt = aae_pkg::S_IDLE;
      aae_pkg::S_IDLE:       if (in_valid) state_nxt = aae_pkg::S_RD_HI;
      aae_pkg::S_RD_HI:      state_nxt = aae_pkg::S_RD_TOT;
      aae_pkg::S_RD_TOT:     state_nxt = aae_pkg::S_MUL_LO;
      aae_pkg::S_MUL_LO:     state_nxt = aae_pkg::S_DIV_LO;
      aae_pkg::S_DIV_LO:     if (sts.div_done) state_nxt = aae_pkg::S_MUL_HI;
      aae_pkg::S_MUL_HI:     state_nxt = aae_pkg::S_DIV_HI;
      aae_pkg::S_DIV_HI:     if (sts.div_done) state_nxt = aae_pkg::S_SET_HI;
      aae_pkg::S_SET_HI: begin
        // the table is rebuilt after end of stream, so adaptation is skipped
        state_nxt = sts.eos ? aae_pkg::S_RENORM : aae_pkg::S_INC;
      end
      aae_pkg::S_INC: begin
        if (sts.sweep_done)
          state_nxt = sts.need_halve ? aae_pkg::S_HALVE_INIT : aae_pkg::S_RENORM;
      end
      aae_pkg::S_HALVE_INIT: state_nxt = aae_pkg::S_HALVE;
      aae_pkg::S_HALVE:      if (sts.sweep_done) state_nxt = aae_pkg::S_RENORM;
      aae_pkg::S_RENORM: begin
        if (sts.rn_stop) begin
          if (sts.eos) state_nxt = aae_pkg::S_FIN;
          else if (sts.fifo_empty) state_nxt = aae_pkg::S_IDLE;
          else state_nxt = aae_pkg::S_DRD;
        end else if (sts.rn_emit && sts.pend_nz) begin
          state_nxt = aae_pkg::S_PEND;
        end
      end
      aae_pkg::S_PEND:       if (sts.pend_last) state_nxt = aae_pkg::S_RENORM;
      aae_pkg::S_FIN:        state_nxt = aae_pkg::S_FPEND;
      aae_pkg::S_FPEND:      if (sts.pend_last) state_nxt = aae_pkg::S_FLUSH;
      aae_pkg::S_FLUSH:      state_nxt = aae_pkg::S_DRD;
      aae_pkg::S_DRD:        state_nxt = aae_pkg::S_SHOW;
      aae_pkg::S_SHOW: begin
        if (out_ready) begin
          if (!sts.drain_last) state_nxt = aae_pkg::S_DRD;
          else state_nxt = sts.eos ? aae_pkg::S_CLEAR : aae_pkg::S_IDLE;
        end
      end
      default:               state_nxt = aae_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd.op        = aae_pkg::OP_NONE;
    cmd.dop       = aae_pkg::OPX_NONE;
    cmd.out_taken = 1'b0;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    unique case (state_r)
      aae_pkg::S_CLEAR:      cmd.op = aae_pkg::OP_CLR;
      aae_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = aae_pkg::OP_LOAD;
      end
      aae_pkg::S_RD_HI:      cmd.op = aae_pkg::OP_RD_HI;
      aae_pkg::S_RD_TOT:     cmd.op = aae_pkg::OP_RD_TOT;
      aae_pkg::S_MUL_LO:     cmd.op = aae_pkg::OP_MUL_LO;
      aae_pkg::S_DIV_LO:     cmd.op = aae_pkg::OP_DIV;
      aae_pkg::S_MUL_HI:     cmd.op = aae_pkg::OP_MUL_HI;
      aae_pkg::S_DIV_HI:     cmd.op = aae_pkg::OP_DIV;
      aae_pkg::S_SET_HI:     cmd.op = aae_pkg::OP_SET_HI;
      aae_pkg::S_INC:        cmd.op = aae_pkg::OP_INC;
      aae_pkg::S_HALVE_INIT: cmd.op = aae_pkg::OP_HALVE_INIT;
      aae_pkg::S_HALVE:      cmd.op = aae_pkg::OP_HALVE;
      aae_pkg::S_RENORM:     cmd.op = aae_pkg::OP_RENORM;
      aae_pkg::S_PEND:       cmd.op = aae_pkg::OP_PEND;
      aae_pkg::S_FIN:        cmd.op = aae_pkg::OP_FIN;
      aae_pkg::S_FPEND:      cmd.op = aae_pkg::OP_PEND;
      aae_pkg::S_FLUSH:      cmd.op = aae_pkg::OP_FLUSH;
      aae_pkg::S_DRD:        cmd.dop = aae_pkg::OPX_DRD;
      aae_pkg::S_SHOW: begin
        cmd.dop       = aae_pkg::OPX_SHOW;
        out_valid     = 1'b1;
        cmd.out_taken = out_ready;
      end
      default:               cmd.op = aae_pkg::OP_NONE;
    endcase
  end

endmodule

/* rtl/core/aae_dp.sv */
// Datapath: count table, interval divider, renormalizer, bit packer and result buffer.
module aae_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [aae_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic [7:0]                   in_sym,
  input  logic                         in_eos,
  input  aae_pkg::dp_cmd_t             cmd,
  output aae_pkg::dp_sts_t             sts,
  output logic [7:0]                   res_byte,
  output logic                         res_last,
  output logic                         res_done,
  output logic                         res_ovf
);

  localparam int unsigned CW = aae_pkg::CNT_W;
  localparam int unsigned WW = aae_pkg::WORK_W;
  localparam int unsigned PW = aae_pkg::PROD_W;
  localparam int unsigned AW = aae_pkg::TBL_AW;
  localparam int unsigned RW = aae_pkg::RES_AW;

  logic [CW-1:0] tbl_mem [aae_pkg::TBL_DEPTH];
  logic [7:0]    res_mem [aae_pkg::RES_MAX];

  logic [CW-1:0]  limit_r;
  logic [AW-1:0]  sym_r, sym_nxt;
  logic           eos_r, eos_nxt;
  logic           sat_r, sat_nxt;
  logic [15:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic [WW-1:0]  nl_r, nl_nxt, nh_r, nh_nxt;
  logic [CW-1:0]  lc_r, lc_nxt, hc_r, hc_nxt, sc_r, sc_nxt;
  logic [CW-1:0]  rem_r, rem_nxt;
  logic [PW-1:0]  dvd_r, dvd_nxt;
  logic [aae_pkg::DIVC_W-1:0] dcnt_r, dcnt_nxt;
  logic [aae_pkg::PEND_W-1:0] pend_r, pend_nxt;
  logic [7:0]     bb_r, bb_nxt;
  logic [2:0]     bc_r, bc_nxt;
  logic           cur_r, cur_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic           pv_r, pv_nxt;
  logic [AW-1:0]  pa_r, pa_nxt;
  logic [CW-1:0]  porig_r, porig_nxt, pnew_r, pnew_nxt;
  logic [CW-1:0]  rd_data_r;
  logic [RW-1:0]  fcnt_r, fcnt_nxt, fidx_r, fidx_nxt;
  logic [7:0]     fdata_r;

  logic [AW-1:0]  rd_addr;
  logic           tw_en;
  logic [AW-1:0]  tw_addr;
  logic [CW-1:0]  tw_data;
  logic           emit_en, emit_val, push;
  logic [7:0]     push_byte, emit_tmp;
  logic [WW-1:0]  range;
  logic [CW-1:0]  divisor, diff, dhalf, hnew, tot_nxt;
  logic [CW:0]    rem_sh;
  logic           qbit;
  logic [WW:0]    tsum, tdec;
  logic           add_pend;
  logic           rn_stop, rn_emit;

  assign range   = {1'b0, hi_r} - {1'b0, lo_r} + WW'(1);
  assign divisor = (sc_r == '0) ? CW'(1) : sc_r;
  assign rem_sh  = {rem_r, dvd_r[PW-1]};
  assign qbit    = (rem_sh >= {1'b0, divisor});
  assign tot_nxt = sc_r + CW'(1);
  assign diff    = rd_data_r - porig_r;
  assign dhalf   = (diff > CW'(1)) ? (diff >> 1) : diff;
  assign hnew    = pnew_r + dhalf;
  assign tsum    = {2'b00, lo_r} + {1'b0, dvd_r[WW-1:0]};
  assign tdec    = (tsum == '0) ? '0 : tsum - (WW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= CW'(16383);
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // table read address and write port
  always_comb begin
    rd_addr = idx_r;
    tw_en   = 1'b0;
    tw_addr = pa_r;
    tw_data = rd_data_r + CW'(1);
    case (cmd.op)
      aae_pkg::OP_LOAD:   rd_addr = in_eos ? AW'(aae_pkg::EOS_SYM) : {1'b0, in_sym};
      aae_pkg::OP_RD_HI:  rd_addr = sym_r + AW'(1);
      aae_pkg::OP_RD_TOT: rd_addr = AW'(aae_pkg::TBL_DEPTH - 1);
      aae_pkg::OP_CLR: begin
        tw_en   = 1'b1;
        tw_addr = idx_r;
        tw_data = CW'(idx_r);
      end
      aae_pkg::OP_INC:    tw_en = pv_r;
      aae_pkg::OP_HALVE: begin
        tw_en   = pv_r;
        tw_data = hnew;
      end
      default:            rd_addr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tw_en) tbl_mem[tw_addr] <= tw_data;
    rd_data_r <= tbl_mem[rd_addr];
  end

  always_comb begin
    sym_nxt   = sym_r;    eos_nxt  = eos_r;   sat_nxt  = sat_r;
    lo_nxt    = lo_r;     hi_nxt   = hi_r;    nl_nxt   = nl_r;   nh_nxt = nh_r;
    lc_nxt    = lc_r;     hc_nxt   = hc_r;    sc_nxt   = sc_r;
    rem_nxt   = rem_r;    dvd_nxt  = dvd_r;   dcnt_nxt = dcnt_r;
    pend_nxt  = pend_r;   cur_nxt  = cur_r;   idx_nxt  = idx_r;
    pv_nxt    = 1'b0;     pa_nxt   = pa_r;
    porig_nxt = porig_r;  pnew_nxt = pnew_r;
    fcnt_nxt  = fcnt_r;   fidx_nxt = fidx_r;
    emit_en   = 1'b0;     emit_val = 1'b0;    add_pend = 1'b0;

    rn_stop = 1'b0;
    rn_emit = 1'b0;

    case (cmd.op)
      aae_pkg::OP_CLR: begin
        idx_nxt  = (idx_r == AW'(aae_pkg::TBL_DEPTH - 1)) ? '0 : idx_r + AW'(1);
        lo_nxt   = '0;
        hi_nxt   = 16'(aae_pkg::RANGE_TOP);
        pend_nxt = '0;
      end
      aae_pkg::OP_LOAD: begin
        sym_nxt  = in_eos ? AW'(aae_pkg::EOS_SYM) : {1'b0, in_sym};
        eos_nxt  = in_eos;
        sat_nxt  = 1'b0;
        fcnt_nxt = '0;
        fidx_nxt = '0;
      end
      aae_pkg::OP_RD_HI:  lc_nxt = rd_data_r;
      aae_pkg::OP_RD_TOT: hc_nxt = rd_data_r;
      aae_pkg::OP_MUL_LO: begin
        sc_nxt   = rd_data_r;
        dvd_nxt  = PW'(range) * PW'(lc_r);
        rem_nxt  = '0;
        dcnt_nxt = '0;
      end
      aae_pkg::OP_DIV: begin
        rem_nxt  = qbit ? CW'(rem_sh - {1'b0, divisor}) : rem_sh[CW-1:0];
        dvd_nxt  = {dvd_r[PW-2:0], qbit};
        dcnt_nxt = dcnt_r + 1'b1;
      end
      aae_pkg::OP_MUL_HI: begin
        nl_nxt   = WW'({1'b0, lo_r} + dvd_r[WW-1:0]);
        dvd_nxt  = PW'(range) * PW'(hc_r);
        rem_nxt  = '0;
        dcnt_nxt = '0;
      end
      aae_pkg::OP_SET_HI: begin
        // empty interval collapses onto the new low
        nh_nxt  = (tdec < {1'b0, nl_r}) ? nl_r : tdec[WW-1:0];
        idx_nxt = sym_r + AW'(1);
      end
      aae_pkg::OP_INC, aae_pkg::OP_HALVE: begin
        if (idx_r != AW'(aae_pkg::TBL_DEPTH)) begin
          pv_nxt  = 1'b1;
          pa_nxt  = idx_r;
          idx_nxt = idx_r + AW'(1);
        end
        if (cmd.op == aae_pkg::OP_HALVE && pv_r) begin
          porig_nxt = rd_data_r;
          pnew_nxt  = hnew;
        end
      end
      aae_pkg::OP_HALVE_INIT: begin
        idx_nxt   = AW'(1);
        porig_nxt = '0;
        pnew_nxt  = '0;
      end
      aae_pkg::OP_RENORM: begin
        if (nh_r < WW'(aae_pkg::HALF)) begin
          emit_en = 1'b1; emit_val = 1'b0; rn_emit = 1'b1;
          nl_nxt  = nl_r << 1;
          nh_nxt  = (nh_r << 1) | WW'(1);
        end else if (nl_r >= WW'(aae_pkg::HALF)) begin
          emit_en = 1'b1; emit_val = 1'b1; rn_emit = 1'b1;
          nl_nxt  = (nl_r - WW'(aae_pkg::HALF)) << 1;
          nh_nxt  = ((nh_r - WW'(aae_pkg::HALF)) << 1) | WW'(1);
        end else if (nl_r >= WW'(aae_pkg::QTR) && nh_r < WW'(aae_pkg::Q3)) begin
          add_pend = 1'b1;
          nl_nxt   = (nl_r - WW'(aae_pkg::QTR)) << 1;
          nh_nxt   = ((nh_r - WW'(aae_pkg::QTR)) << 1) | WW'(1);
        end else begin
          rn_stop = 1'b1;
          lo_nxt  = nl_r[15:0];
          hi_nxt  = nh_r[15:0];
        end
        cur_nxt = ~emit_val;
      end
      aae_pkg::OP_PEND: begin
        emit_en  = 1'b1;
        emit_val = cur_r;
        pend_nxt = pend_r - 1'b1;
      end
      aae_pkg::OP_FIN: begin
        add_pend = 1'b1;
        emit_en  = 1'b1;
        emit_val = (lo_r >= 16'(aae_pkg::QTR));
        cur_nxt  = ~emit_val;
      end
      aae_pkg::OP_FLUSH: idx_nxt = '0;
      default: ;
    endcase

    if (add_pend) begin
      if (pend_r >= aae_pkg::PEND_W'(aae_pkg::PENDING_MAX)) begin
        pend_nxt = aae_pkg::PEND_W'(aae_pkg::PENDING_MAX);
        sat_nxt  = 1'b1;
      end else begin
        pend_nxt = pend_r + 1'b1;
      end
    end

    if (cmd.out_taken) fidx_nxt = fidx_r + 1'b1;
  end

  // MSB-first bit packer
  always_comb begin
    bb_nxt    = bb_r;
    bc_nxt    = bc_r;
    push      = 1'b0;
    push_byte = bb_r;
    emit_tmp  = bb_r | (8'(emit_val) << (3'd7 - bc_r));
    if (emit_en) begin
      if (bc_r == 3'd7) begin
        push      = 1'b1;
        push_byte = emit_tmp;
        bb_nxt    = '0;
        bc_nxt    = '0;
      end else begin
        bb_nxt = emit_tmp;
        bc_nxt = bc_r + 3'd1;
      end
    end else if (cmd.op == aae_pkg::OP_FLUSH && bc_r != '0) begin
      push = 1'b1;
    end
    if (cmd.op == aae_pkg::OP_CLR) begin
      bb_nxt = '0;
      bc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && fcnt_r < RW'(aae_pkg::RES_MAX)) res_mem[fcnt_r] <= push_byte;
    if (cmd.dop == aae_pkg::OPX_DRD) fdata_r <= res_mem[fidx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      pv_r   <= 1'b0;
      dcnt_r <= '0;
      fcnt_r <= '0;
      fidx_r <= '0;
      eos_r  <= 1'b0;
      sat_r  <= 1'b0;
      pend_r <= '0;
      bb_r   <= '0;
      bc_r   <= '0;
    end else begin
      idx_r  <= idx_nxt;
      pv_r   <= pv_nxt;
      dcnt_r <= dcnt_nxt;
      fcnt_r <= (push && fcnt_r < RW'(aae_pkg::RES_MAX)) ? fcnt_nxt + 1'b1 : fcnt_nxt;
      fidx_r <= fidx_nxt;
      eos_r  <= eos_nxt;
      sat_r  <= sat_nxt;
      pend_r <= pend_nxt;
      bb_r   <= bb_nxt;
      bc_r   <= bc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r   <= sym_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    nl_r    <= nl_nxt;
    nh_r    <= nh_nxt;
    lc_r    <= lc_nxt;
    hc_r    <= hc_nxt;
    sc_r    <= sc_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    cur_r   <= cur_nxt;
    pa_r    <= pa_nxt;
    porig_r <= porig_nxt;
    pnew_r  <= pnew_nxt;
  end

  assign sts.clr_last   = (idx_r == AW'(aae_pkg::TBL_DEPTH - 1));
  assign sts.div_done   = (dcnt_r == aae_pkg::DIVC_W'(PW - 1));
  assign sts.sweep_done = (idx_r == AW'(aae_pkg::TBL_DEPTH)) && !pv_r;
  assign sts.need_halve = (tot_nxt >= limit_r);
  assign sts.rn_stop    = rn_stop;
  assign sts.rn_emit    = rn_emit;
  assign sts.pend_nz    = (pend_r != '0);
  assign sts.pend_last  = (pend_r == aae_pkg::PEND_W'(1));
  assign sts.fifo_empty = (fcnt_r == '0);
  assign sts.drain_last = (fidx_r == fcnt_r - 1'b1);
  assign sts.eos        = eos_r;

  assign res_byte = fdata_r;
  assign res_last = sts.drain_last;
  assign res_done = eos_r && sts.drain_last;
  assign res_ovf  = sat_r;

endmodule

/* rtl/core/adaptive_arith_encoder_top.sv */
// Top level of the order-0 adaptive arithmetic encoder.
// Usage:
//   in_ch carries one byte (sym_byte) or an end-of-stream mark per transfer.
//   out_ch carries the coded bytes an item produced, MSB-first packing, with
//   last_of_run on the final byte of the item, stream_done on the final byte
//   of the stream and pending_overflow on every byte of an item in which the
//   underflow counter saturated. An item that completes no byte gives none.
//   cfg_we/cfg_wdata set the rescale limit; write only while idle.
// Flow: one item at a time. An item runs the two 31-step serial divisions,
//   then a sweep of the count table entries above the symbol, a sweep of
//   the table when the counts are halved, the renormalization steps and
//   pending bits, and the drain of its result bytes. End of stream skips
//   the count update and adds a finish and a flush step. The count table,
//   with one read and one write port, is swept one entry a cycle.
// Reset and end of stream run a pass that reloads all 258 count table entries;
//   in_ch is not ready during it.
// Results are buffered until the item is done; a stalled receiver holds the
//   current byte and the block takes no new item until all are transferred.
module adaptive_arith_encoder_top (
  input  logic                         clk,
  input  logic                         rst_n,
  aae_in_if.sink                       in_ch,
  aae_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [aae_pkg::CNT_W-1:0]    cfg_wdata
);

  aae_pkg::dp_cmd_t cmd;
  aae_pkg::dp_sts_t sts;

  aae_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  aae_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_sym    (in_ch.sym_byte),
    .in_eos    (in_ch.end_of_stream),
    .cmd       (cmd),
    .sts       (sts),
    .res_byte  (out_ch.out_byte),
    .res_last  (out_ch.last_of_run),
    .res_done  (out_ch.stream_done),
    .res_ovf   (out_ch.pending_overflow)
  );

endmodule

/* rtl/core/aae_checker.sv */
// Port-level checks of the encoder, bound to the top level.
module aae_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       stream_done,
  input logic       pending_overflow
);

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stream_done |-> last_of_run)
    else $error("stream_done without last_of_run");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run)
      && $stable(pending_overflow))
    else $error("stalled result changed");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while results drain");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last_of_run |=> !out_valid)
    else $error("result after last of run");

endmodule

bind adaptive_arith_encoder_top aae_checker u_aae_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_byte         (out_ch.out_byte),
  .last_of_run      (out_ch.last_of_run),
  .stream_done      (out_ch.stream_done),
  .pending_overflow (out_ch.pending_overflow)
);

/* tb/tb_adaptive_arith_encoder_top.sv */
// Self-checking testbench of the adaptive arithmetic encoder with a built-in bit-exact predictor.
module tb_adaptive_arith_encoder_top;

  localparam int unsigned IDLE_LIMIT  = 20000;
  localparam int unsigned SETTLE      = 1200;
  localparam int unsigned HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       done;
    logic       ovf;
  } coded_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [aae_pkg::CNT_W-1:0]    cfg_wdata = '0;

  aae_in_if  in_ch ();
  aae_out_if out_ch ();

  adaptive_arith_encoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  coded_t      coded_q[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  bit          no_idle = 0;
  bit          hold_on = 0;
  event        hold_ev;

  // encoder shadow state
  int unsigned freq[aae_pkg::TBL_DEPTH];
  int unsigned enc_low, enc_high, enc_pend, enc_buf, enc_cnt, enc_limit;
  logic [7:0]  run_bytes[$];
  bit          run_sat;

  function automatic void clear_coder();
    for (int i = 0; i < aae_pkg::TBL_DEPTH; i++) freq[i] = i;
    enc_low = 0;
    enc_high = aae_pkg::RANGE_TOP;
    enc_pend = 0;
    enc_buf = 0;
    enc_cnt = 0;
  endfunction

  function automatic void put_bit(int unsigned b);
    int unsigned pos;
    pos = enc_cnt & 7;
    enc_buf = (enc_buf | ((b & 1) << (7 - pos))) & 8'hFF;
    enc_cnt = pos + 1;
    if (enc_cnt == 8) begin
      if (run_bytes.size() < aae_pkg::RES_MAX) run_bytes.push_back(enc_buf[7:0]);
      enc_buf = 0;
      enc_cnt = 0;
    end
  endfunction

  function automatic void put_with_pending(int unsigned b);
    put_bit(b);
    while (enc_pend > 0) begin
      put_bit(b ^ 1);
      enc_pend--;
    end
  endfunction

  function automatic void bump_pending();
    if (enc_pend >= aae_pkg::PENDING_MAX) begin
      enc_pend = aae_pkg::PENDING_MAX;
      run_sat = 1;
    end else begin
      enc_pend++;
    end
  endfunction

  function automatic void update_counts(int unsigned s);
    int unsigned prev, d;
    for (int unsigned i = s + 1; i < aae_pkg::TBL_DEPTH; i++) begin
      freq[i] = (freq[i] + 1) & 14'h3FFF;
    end
    if (freq[aae_pkg::TBL_DEPTH-1] < enc_limit) return;
    prev = 0;
    for (int unsigned i = 1; i < aae_pkg::TBL_DEPTH; i++) begin
      d = freq[i] - prev;
      if (d > 1) d = d / 2;
      prev = freq[i];
      freq[i] = freq[i-1] + d;
    end
  endfunction

  function automatic void code_symbol(int unsigned s);
    longint unsigned rng, nl, nh, tot;
    tot = freq[aae_pkg::TBL_DEPTH-1];
    if (tot == 0) tot = 1;
    rng = longint'(enc_high) - enc_low + 1;
    nl = enc_low + rng * freq[s] / tot;
    nh = enc_low + rng * freq[s+1] / tot;
    nh = (nh > 0) ? nh - 1 : 0;
    if (nh < nl) nh = nl;
    update_counts(s);
    forever begin
      if (nh < aae_pkg::HALF) begin
        put_with_pending(0);
        nl = 2 * nl;
        nh = 2 * nh + 1;
      end else if (nl >= aae_pkg::HALF) begin
        put_with_pending(1);
        nl = 2 * (nl - aae_pkg::HALF);
        nh = 2 * (nh - aae_pkg::HALF) + 1;
      end else if (nl >= aae_pkg::QTR && nh < aae_pkg::Q3) begin
        bump_pending();
        nl = 2 * (nl - aae_pkg::QTR);
        nh = 2 * (nh - aae_pkg::QTR) + 1;
      end else begin
        break;
      end
    end
    enc_low = nl & 16'hFFFF;
    enc_high = nh & 16'hFFFF;
  endfunction

  function automatic void predict_item(logic [7:0] b, logic eos);
    coded_t r;
    run_bytes.delete();
    run_sat = 0;
    if (eos) begin
      code_symbol(aae_pkg::EOS_SYM);
      bump_pending();
      put_with_pending(enc_low >= aae_pkg::QTR ? 1 : 0);
      if (enc_cnt != 0 && run_bytes.size() < aae_pkg::RES_MAX) begin
        run_bytes.push_back(enc_buf[7:0]);
      end
      clear_coder();
    end else begin
      code_symbol(b);
    end
    for (int k = 0; k < run_bytes.size(); k++) begin
      r.code = run_bytes[k];
      r.last = (k == run_bytes.size() - 1);
      r.done = eos && (k == run_bytes.size() - 1);
      r.ovf = run_sat;
      coded_q.push_back(r);
    end
  endfunction

  // one input transfer, with a random gap before it
  task automatic send_item(logic [7:0] b, logic eos);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sym_byte <= b;
    in_ch.end_of_stream <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(b, eos);
    items_sent++;
  endtask

  task automatic write_limit(logic [aae_pkg::CNT_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    enc_limit = v;
  endtask

  // random stream ending in end-of-stream; narrow alphabets drive runs and pending bits
  task automatic send_stream(int unsigned len);
    logic [7:0] mask, base;
    mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'h03;
    base = 8'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0);
      else send_item(base ^ (8'($urandom) & mask), 1'b0);
    end
    send_item(8'($urandom), 1'b1);
  endtask

  task automatic test_directed();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h00, 1'b1);
    // empty stream
    send_item(8'hFF, 1'b1);
    for (int i = 0; i < 12; i++) send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_small_limit();
    write_limit(aae_pkg::CNT_W'(258));
    for (int i = 0; i < 8; i++) send_item(i[0] ? 8'hFF : 8'h01, 1'b0);
    send_item(8'h00, 1'b1);
    send_stream(40);
  endtask

  task automatic test_random_limits();
    write_limit(aae_pkg::CNT_W'(16383));
    repeat (4) send_stream($urandom_range(1, 30));
    write_limit(aae_pkg::CNT_W'(300));
    repeat (3) send_stream($urandom_range(1, 30));
    write_limit(aae_pkg::CNT_W'($urandom_range(258, 16383)));
    repeat (3) send_stream($urandom_range(1, 30));
  endtask

  task automatic test_no_idle();
    no_idle = 1;
    write_limit(aae_pkg::CNT_W'(1000));
    repeat (3) send_stream($urandom_range(20, 60));
    no_idle = 0;
  endtask

  task automatic test_backpressure();
    -> hold_ev;
    send_stream(30);
  endtask

  task automatic test_fill();
    write_limit(aae_pkg::CNT_W'(16383));
    while (items_sent < 480) send_stream($urandom_range(1, 60));
  endtask

  // long receiver hold
  always begin
    @(hold_ev);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // result checker and receiver stall
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    coded_t got, want;
    if (out_ch.valid && out_ch.ready) begin
      got = {out_ch.out_byte, out_ch.last_of_run, out_ch.stream_done,
             out_ch.pending_overflow};
      if (coded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %h", $realtime, got);
      end else begin
        want = coded_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch, expected byte %h last %b done %b ovf %b,",
                   $realtime, want.code, want.last, want.done, want.ovf);
          $display("    actual byte %h last %b done %b ovf %b",
                   got.code, got.last, got.done, got.ovf);
        end
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 8);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_ch.ready <= (stall_left == 0) && !hold_on;
  end

  int unsigned quiet = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("tb_adaptive_arith_encoder_top failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sym_byte = '0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready = 1'b0;
    clear_coder();
    enc_limit = 16383;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (400) @(posedge clk);
    test_directed();
    test_small_limit();
    test_random_limits();
    test_no_idle();
    test_backpressure();
    test_fill();
    in_ch.valid <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("tb_adaptive_arith_encoder_top passed");
    end else begin
      $display("tb_adaptive_arith_encoder_top failed");
    end
    $finish;
  end

endmodule
